// ----- hw/rtl/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Fixed field widths of the request and result words.
    localparam int PRIO_W    = 8;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;

    // Request modes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Request word.
    typedef struct packed {
        logic                     mode;
        logic signed [PRIO_W-1:0] priority_req;
        logic [WORD_W-1:0]        payload;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [PRIO_W-1:0] out_priority;
        logic [WORD_W-1:0]        out_payload;
        logic [FILL_W-1:0]        fill_count;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ----- hw/rtl/spq_ctrl.sv -----
// Controller state machine that sequences capture, update and report of one word.
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_valid,
    output spq_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state: capture, update the cells, then present the result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands and handshake outputs.
    assign busy       = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_DONE);
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

// ----- hw/rtl/spq_datapath.sv -----
// Datapath: request register, sorted row of queue cells, fill count and result register.
`timescale 1ns / 1ps

module spq_datapath #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_dp_cmd   i_cmd,
    input  spq_pkg::t_in_word  i_word,
    output spq_pkg::t_out_word o_result
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SW    = (PAYLOAD_BITS < spq_pkg::WORD_W) ? PAYLOAD_BITS : spq_pkg::WORD_W;

    spq_pkg::t_in_word  r_req;
    spq_pkg::t_out_word r_res;
    spq_pkg::t_out_word n_res;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;

    // Cell row, head at index 0.
    logic signed [spq_pkg::PRIO_W-1:0] r_prio [DEPTH];
    logic [SW-1:0]                     r_data [DEPTH];
    logic [DEPTH-1:0]                  ge;

    logic is_full;
    logic is_empty;
    logic do_insert;
    logic do_remove;

    assign is_full   = (r_cnt == CNT_W'(DEPTH));
    assign is_empty  = (r_cnt == '0);
    assign do_insert = i_cmd.exec && (r_req.mode == spq_pkg::MODE_INSERT) && !is_full;
    assign do_remove = i_cmd.exec && (r_req.mode == spq_pkg::MODE_REMOVE) && !is_empty;

    // Capture the request word when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_word;
        end
    end

    // Each cell compares its own priority with the new one; the held cells form a prefix.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign ge[gi] = (CNT_W'(gi) < r_cnt) && (r_prio[gi] >= r_req.priority_req);

            logic signed [spq_pkg::PRIO_W-1:0] n_prio;
            logic [SW-1:0]                     n_data;
            logic                              take_new;

            // The first cell below all higher-or-equal entries takes the new word.
            if (gi == 0) begin : g_head
                assign take_new = !ge[gi];
            end else begin : g_body
                assign take_new = !ge[gi] && ge[gi-1];
            end

            // Insert shifts lower cells back by one; remove shifts all forward by one.
            always_comb begin
                n_prio = r_prio[gi];
                n_data = r_data[gi];
                if (do_insert) begin
                    if (take_new) begin
                        n_prio = r_req.priority_req;
                        n_data = r_req.payload[SW-1:0];
                    end else if (!ge[gi]) begin
                        n_prio = r_prio[(gi == 0) ? 0 : gi - 1];
                        n_data = r_data[(gi == 0) ? 0 : gi - 1];
                    end
                end else if (do_remove) begin
                    n_prio = r_prio[(gi == DEPTH - 1) ? gi : gi + 1];
                    n_data = r_data[(gi == DEPTH - 1) ? gi : gi + 1];
                end
            end

            always_ff @(posedge i_clk) begin
                r_prio[gi] <= n_prio;
                r_data[gi] <= n_data;
            end
        end
    endgenerate

    // Fill count and result word.
    always_comb begin
        n_cnt              = r_cnt;
        n_res.out_priority = '0;
        n_res.out_payload  = '0;
        priority if (r_req.mode == spq_pkg::MODE_INSERT && is_full) begin
            n_res.status = spq_pkg::ST_FULL;
        end else if (r_req.mode == spq_pkg::MODE_INSERT) begin
            n_res.status = spq_pkg::ST_INSERTED;
            n_cnt        = r_cnt + CNT_W'(1);
        end else if (is_empty) begin
            n_res.status = spq_pkg::ST_EMPTY;
        end else begin
            n_res.status       = spq_pkg::ST_REMOVED;
            n_res.out_priority = r_prio[0];
            n_res.out_payload  = spq_pkg::WORD_W'(r_data[0]);
            n_cnt              = r_cnt - CNT_W'(1);
        end
        n_res.fill_count = spq_pkg::FILL_W'(n_cnt);
    end

    // Count register is control state; the result word needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.exec) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

// ----- hw/rtl/stable_priority_queue.sv -----
// Top level of the stable priority queue: controller plus datapath.
`timescale 1ns / 1ps

// Each word is captured when start is high while busy is low, the row of DEPTH
// queue cells is updated in parallel in the next cycle, and the result is then shown
// on o_result with o_valid high for exactly one cycle. The
// receiver cannot hold a result off, so it must take it in that cycle. The next word
// can be accepted in the cycle after the result; busy is high from acceptance through
// the result cycle. Inserts keep equal priorities in arrival order; an insert into a
// full queue reports full, a remove from an empty queue reports empty, and every
// result carries the fill count modulo 32.
module stable_priority_queue #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  spq_pkg::t_in_word  i_word,
    output logic               o_valid,
    output spq_pkg::t_out_word o_result
);

    spq_pkg::t_dp_cmd dp_cmd;

    // Sequencer.
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd)
    );

    // Queue cells and result.
    spq_datapath #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_word   (i_word),
        .o_result (o_result)
    );

endmodule

// ----- test/tb_stable_priority_queue.sv -----
// Self-checking testbench for the stable priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_stable_priority_queue;

    localparam int QDEPTH     = spq_pkg::DEPTH_DEF;
    localparam int PHASE_LEN  = 600;
    localparam int STALL_MAX  = 500;
    localparam int NUM_ROWS   = 25;

    // One row of the directed table: the request word and, where it is obvious,
    // the result typed in by hand.
    typedef struct packed {
        spq_pkg::t_in_word  w;
        logic               has_exp;
        spq_pkg::t_out_word exp;
    } t_row;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    spq_pkg::t_in_word  i_word  = '0;
    logic               busy;
    logic               o_valid;
    spq_pkg::t_out_word o_result;

    // Hand-typed expectation that travels with the word currently on offer.
    logic               row_has_exp = 1'b0;
    spq_pkg::t_out_word row_exp     = '0;

    // Shadow copy of the queue contents, head at index 0.
    logic signed [spq_pkg::PRIO_W-1:0] held_prio [QDEPTH];
    logic [spq_pkg::WORD_W-1:0]        held_data [QDEPTH];
    int                                held_n = 0;

    spq_pkg::t_out_word pending_results [$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    int                 n_inserted = 0;
    int                 n_removed = 0;
    int                 n_full = 0;
    int                 n_empty = 0;
    t_row               rows [NUM_ROWS];

    stable_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // Advance the shadow queue by one request and return the result it should give.
    function automatic spq_pkg::t_out_word queue_update(input spq_pkg::t_in_word w);
        spq_pkg::t_out_word                r;
        logic signed [spq_pkg::PRIO_W-1:0] p;
        int                                pos;
        r = '0;
        p = w.priority_req;
        if (w.mode == spq_pkg::MODE_INSERT) begin
            if (held_n >= QDEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                // Stable placement: behind every entry of equal or higher priority.
                pos = 0;
                while (pos < held_n && held_prio[pos] >= p) pos++;
                for (int i = held_n; i > pos; i--) begin
                    held_prio[i] = held_prio[i-1];
                    held_data[i] = held_data[i-1];
                end
                held_prio[pos] = p;
                held_data[pos] = w.payload;
                held_n++;
                r.status = spq_pkg::ST_INSERTED;
            end
        end else if (held_n == 0) begin
            r.status = spq_pkg::ST_EMPTY;
        end else begin
            r.status       = spq_pkg::ST_REMOVED;
            r.out_priority = held_prio[0];
            r.out_payload  = held_data[0];
            for (int i = 1; i < held_n; i++) begin
                held_prio[i-1] = held_prio[i];
                held_data[i-1] = held_data[i];
            end
            held_n--;
        end
        r.fill_count = spq_pkg::FILL_W'(held_n);
        return r;
    endfunction

    // Check each result against the oldest expectation, then log newly accepted words.
    always @(posedge i_clk) begin
        spq_pkg::t_out_word want;
        spq_pkg::t_out_word got;
        if (i_rst_n && o_valid) begin
            got = o_result;
            case (got.status)
                spq_pkg::ST_INSERTED: n_inserted++;
                spq_pkg::ST_REMOVED:  n_removed++;
                spq_pkg::ST_FULL:     n_full++;
                default:              n_empty++;
            endcase
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.out_priority !== want.out_priority) begin
                    $display("%0t: out_priority expected %0d actual %0d",
                             $time, want.out_priority, got.out_priority);
                    errors++;
                end
                if (got.out_payload !== want.out_payload) begin
                    $display("%0t: out_payload expected %h actual %h",
                             $time, want.out_payload, got.out_payload);
                    errors++;
                end
                if (got.fill_count !== want.fill_count) begin
                    $display("%0t: fill_count expected %0d actual %0d",
                             $time, want.fill_count, got.fill_count);
                    errors++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            want = queue_update(i_word);
            pending_results.push_back(row_has_exp ? row_exp : want);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one word, with idle cycles before it at the given rate, and return at the
    // accepting edge.
    task automatic send_word(input spq_pkg::t_in_word w, input logic has_exp,
                             input spq_pkg::t_out_word exp, input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start       <= 1'b1;
        i_word      <= w;
        row_has_exp <= has_exp;
        row_exp     <= exp;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop offering words until every outstanding result has come back.
    task automatic drain_queue();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random request: ties and extremes half the time, so ordering and full/empty get exercised.
    function automatic spq_pkg::t_in_word random_word(input int insert_pct);
        spq_pkg::t_in_word w;
        w.mode = ($urandom_range(99) < insert_pct) ? spq_pkg::MODE_INSERT
                                                   : spq_pkg::MODE_REMOVE;
        case ($urandom_range(3))
            0: w.priority_req = spq_pkg::PRIO_W'($signed($urandom_range(4)) - 2);
            1: w.priority_req = $urandom_range(1) ? 8'sh7f : 8'sh80;
            default: w.priority_req = spq_pkg::PRIO_W'($urandom());
        endcase
        w.payload = $urandom();
        return w;
    endfunction

    initial begin
        int                 idle_pct [3];
        int                 insert_pct;
        spq_pkg::t_out_word no_exp;
        no_exp      = '0;
        idle_pct    = '{9, 85, 0};

        // Directed table; typed results only where they are plain to see.
        rows = '{
            '{'{spq_pkg::MODE_REMOVE, 8'sh7f, 32'hdeadbeef},
              1'b1, '{spq_pkg::ST_EMPTY, 8'sh00, 32'h0, 5'd0}},
            '{'{spq_pkg::MODE_INSERT, 8'sh7f, 32'hffffffff},
              1'b1, '{spq_pkg::ST_INSERTED, 8'sh00, 32'h0, 5'd1}},
            '{'{spq_pkg::MODE_INSERT, 8'sh80, 32'h00000000},
              1'b1, '{spq_pkg::ST_INSERTED, 8'sh00, 32'h0, 5'd2}},
            '{'{spq_pkg::MODE_INSERT, 8'sh00, 32'ha5a5a5a5},
              1'b1, '{spq_pkg::ST_INSERTED, 8'sh00, 32'h0, 5'd3}},
            '{'{spq_pkg::MODE_INSERT, 8'sh00, 32'h5a5a5a5a},
              1'b1, '{spq_pkg::ST_INSERTED, 8'sh00, 32'h0, 5'd4}},
            '{'{spq_pkg::MODE_REMOVE, 8'sh80, 32'h0},
              1'b1, '{spq_pkg::ST_REMOVED, 8'sh7f, 32'hffffffff, 5'd3}},
            '{'{spq_pkg::MODE_REMOVE, 8'sh00, 32'hffffffff}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_REMOVE, 8'sh01, 32'h12345678}, 1'b0, no_exp},
            // Refill to the brim with ties, extremes and mixed signs.
            '{'{spq_pkg::MODE_INSERT, 8'sh80, 32'h00000001}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh7f, 32'h80000000}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh7f, 32'h7fffffff}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'shff, 32'h00000004}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh01, 32'h00000005}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh00, 32'h00000006}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh40, 32'h00000007}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'shc0, 32'h00000008}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh00, 32'h00000009}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh7f, 32'h0000000a}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh80, 32'h0000000b}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh05, 32'h0000000c}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh05, 32'h0000000d}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'shfb, 32'h0000000e}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh01, 32'h0000000f}, 1'b0, no_exp},
            '{'{spq_pkg::MODE_INSERT, 8'sh3c, 32'hcafef00d},
              1'b1, '{spq_pkg::ST_FULL, 8'sh00, 32'h0, 5'd16}},
            '{'{spq_pkg::MODE_REMOVE, 8'sh00, 32'h0}, 1'b0, no_exp}
        };

        // Reset held at the start, once.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_word(rows[r].w, rows[r].has_exp, rows[r].exp, 9);
        end
        drain_queue();

        // Random traffic in three phases of sender idling, draining between phases.
        for (int ph = 0; ph < 3; ph++) begin
            insert_pct = 50;
            for (int n = 0; n < PHASE_LEN; n++) begin
                // Swing the fill level between empty and full every 40 words.
                if (n % 40 == 0) begin
                    case ($urandom_range(2))
                        0: insert_pct = 85;
                        1: insert_pct = 50;
                        default: insert_pct = 15;
                    endcase
                end
                send_word(random_word(insert_pct), 1'b0, no_exp, idle_pct[ph]);
            end
            drain_queue();
        end

        // Let any stray result show up before the verdict.
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
        end

        $display("Covered %0d inserts, %0d removes, %0d full rejects, %0d empty removes",
                 n_inserted, n_removed, n_full, n_empty);
        $display("over a directed table and three idling phases of random traffic.");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
